FILE: design/sdwd_pkg.sv
package sdwd_pkg;

    localparam int DICT_BYTES_DEF = 32768;
    localparam int MSG_BYTES_DEF  = 256;

    // request codes
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_DICT  = 2'd1;
    localparam logic [1:0] REQ_MSG   = 2'd2;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0a;

    // separator characters removed from the message
    function automatic logic is_drop(input logic [7:0] b);
        return b == 8'h09 || b == 8'h20 || b == 8'h5f || b == 8'h2d ||
               b == 8'h2e || b == 8'h3a || b == 8'h5e;
    endfunction

    // recognised double-byte pairs; their trailing byte is kept even if it looks like a separator
    function automatic logic is_dbcs(input logic [7:0] hi, input logic [7:0] lo);
        logic r;
        r = 1'b0;
        if (hi == 8'h82 && lo > 8'h9e && lo < 8'hf2) r = 1'b1;
        if (hi == 8'h83 && lo > 8'h3f && lo < 8'h97) r = 1'b1;
        if (hi >= 8'h88 && hi <= 8'h9f && lo > 8'h3f && lo < 8'hfd) r = 1'b1;
        if (hi >= 8'he0 && hi <= 8'hfc && lo > 8'h3f && lo < 8'hfd) r = 1'b1;
        return r;
    endfunction

endpackage

FILE: design/sdwd_if.sv
interface sdwd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       last;
    modport source (output valid, req_type, data_byte, last, input ready);
    modport sink   (input valid, req_type, data_byte, last, output ready);
endinterface

interface sdwd_out_if;
    logic valid;
    logic ready;
    logic is_match;
    logic message_overflow;
    logic dictionary_overflow;
    modport source (output valid, is_match, message_overflow, dictionary_overflow,
                    input ready);
    modport sink   (input valid, is_match, message_overflow, dictionary_overflow,
                    output ready);
endinterface

FILE: design/sjis_dictionary_word_detector.sv
// Shift-JIS aware dictionary word detector. Dictionary text (newline separated
// lines, tab separated fields, first field is the word) and message bytes are
// taken one transfer per cycle while idle; message bytes are filtered of
// separators on the way in, except trailing bytes of double-byte pairs. The
// message transfer flagged last starts a walk over the dictionary memory during
// which the input is held off: leading tabs and newlines are skipped, each word
// is compared byte by byte against every character start of the message
// memory, and the rest of the line is skipped. Every memory access is split
// into an address state and a state that uses the registered read data. The
// result then sits in the output register until taken. No clearing pass: only
// written entries are ever read.
module sjis_dictionary_word_detector
    import sdwd_pkg::*;
#(
    parameter int DICT_BYTES = DICT_BYTES_DEF,
    parameter int MSG_BYTES  = MSG_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdwd_in_if.sink     i_in,
    sdwd_out_if.source  o_out
);
    localparam int DW = $clog2(DICT_BYTES);
    localparam int MW = $clog2(MSG_BYTES);

    typedef enum logic [2:0] {
        S_IDLE, S_LEAD_RD, S_LEAD_EX, S_CMP_RD, S_CMP_EX, S_SKIP_RD, S_SKIP_EX, S_OUT
    } t_state;

    t_state      r_state;
    logic [DW:0] r_dlen;
    logic        r_dfull;
    logic [MW:0] r_mlen;
    logic        r_mfull;
    logic [7:0]  r_prev;
    logic        r_have_prev;
    // walk pointers: dictionary scan, word start, message start and compare
    logic [DW:0] r_q;
    logic [DW:0] r_ws;
    logic [MW:0] r_i;
    logic [MW:0] r_j;
    logic        r_k0;
    logic [7:0]  r_first;
    logic        r_match;
    logic        r_movf;
    logic        r_dovf;

    // memories
    logic [7:0]  dict_mem [DICT_BYTES];
    logic [7:0]  msg_mem  [MSG_BYTES];
    logic [7:0]  r_dict_q;
    logic [7:0]  r_msg_q;

    logic xfer, dict_wr, keep, msg_wr, d_term;
    logic [MW:0] next_i;

    assign xfer    = i_in.valid && i_in.ready;
    assign dict_wr = xfer && i_in.req_type == REQ_DICT && r_dlen < (DW+1)'(DICT_BYTES);
    assign keep    = !is_drop(i_in.data_byte) ||
                     (r_have_prev && is_dbcs(r_prev, i_in.data_byte));
    assign msg_wr  = xfer && i_in.req_type == REQ_MSG && keep &&
                     r_mlen < (MW+1)'(MSG_BYTES);

    // word terminator as seen in the compare
    assign d_term  = r_dict_q == CH_NUL || r_dict_q == CH_TAB || r_dict_q == CH_LF;
    // next character start: bytes with the top bit set step two positions
    assign next_i  = r_i + (r_first[7] ? (MW+1)'(2) : (MW+1)'(1));

    always_ff @(posedge i_clk) begin
        if (dict_wr) begin
            dict_mem[r_dlen[DW-1:0]] <= i_in.data_byte;
        end
        r_dict_q <= dict_mem[r_q[DW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (msg_wr) begin
            msg_mem[r_mlen[MW-1:0]] <= i_in.data_byte;
        end
        r_msg_q <= msg_mem[r_j[MW-1:0]];
    end

    assign i_in.ready               = r_state == S_IDLE;
    assign o_out.valid              = r_state == S_OUT;
    assign o_out.is_match           = r_match;
    assign o_out.message_overflow   = r_movf;
    assign o_out.dictionary_overflow = r_dovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dlen      <= '0;
            r_dfull     <= 1'b0;
            r_mlen      <= '0;
            r_mfull     <= 1'b0;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_q         <= '0;
            r_ws        <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_k0        <= 1'b0;
            r_first     <= '0;
            r_match     <= 1'b0;
            r_movf      <= 1'b0;
            r_dovf      <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (xfer) begin
                        case (i_in.req_type)
                            REQ_CLEAR: begin
                                r_dlen  <= '0;
                                r_dfull <= 1'b0;
                            end
                            REQ_DICT: begin
                                if (dict_wr) r_dlen <= r_dlen + 1'b1;
                                else         r_dfull <= 1'b1;
                            end
                            REQ_MSG: begin
                                if (msg_wr) r_mlen <= r_mlen + 1'b1;
                                if (i_in.last) begin
                                    // capture the flags and start the walk
                                    r_movf      <= r_mfull || (keep && !msg_wr);
                                    r_dovf      <= r_dfull;
                                    r_match     <= 1'b0;
                                    r_mfull     <= 1'b0;
                                    r_prev      <= '0;
                                    r_have_prev <= 1'b0;
                                    r_q         <= '0;
                                    r_state     <= S_LEAD_RD;
                                end else begin
                                    if (keep && !msg_wr) r_mfull <= 1'b1;
                                    r_prev      <= i_in.data_byte;
                                    r_have_prev <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_LEAD_RD: begin
                    if (r_q >= r_dlen) r_state <= S_OUT;
                    else               r_state <= S_LEAD_EX;
                end
                S_LEAD_EX: begin
                    if (r_dict_q == CH_NUL) begin
                        r_state <= S_OUT;
                    end else if (r_dict_q == CH_LF || r_dict_q == CH_TAB) begin
                        r_q     <= r_q + 1'b1;
                        r_state <= S_LEAD_RD;
                    end else begin
                        // word starts here
                        r_ws  <= r_q;
                        r_i   <= '0;
                        r_j   <= '0;
                        r_k0  <= 1'b1;
                        r_state <= (r_mlen == '0) ? S_SKIP_RD : S_CMP_RD;
                    end
                end
                S_CMP_RD: begin
                    if (r_q >= r_dlen) begin
                        r_match <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_CMP_EX;
                    end
                end
                S_CMP_EX: begin
                    if (r_k0) r_first <= r_msg_q;
                    r_k0 <= 1'b0;
                    if (d_term) begin
                        r_match <= 1'b1;
                        r_state <= S_OUT;
                    end else if (r_j < r_mlen && r_dict_q == r_msg_q) begin
                        r_q     <= r_q + 1'b1;
                        r_j     <= r_j + 1'b1;
                        r_state <= S_CMP_RD;
                    end else begin
                        // mismatch: retry the word at the next character start
                        r_q <= r_ws;
                        if (r_k0) begin
                            if ((r_i + (r_msg_q[7] ? (MW+1)'(2) : (MW+1)'(1))) >= r_mlen) begin
                                r_state <= S_SKIP_RD;
                            end else begin
                                r_i     <= r_i + (r_msg_q[7] ? (MW+1)'(2) : (MW+1)'(1));
                                r_j     <= r_i + (r_msg_q[7] ? (MW+1)'(2) : (MW+1)'(1));
                                r_k0    <= 1'b1;
                                r_state <= S_CMP_RD;
                            end
                        end else if (next_i >= r_mlen) begin
                            r_state <= S_SKIP_RD;
                        end else begin
                            r_i     <= next_i;
                            r_j     <= next_i;
                            r_k0    <= 1'b1;
                            r_state <= S_CMP_RD;
                        end
                    end
                end
                S_SKIP_RD: begin
                    if (r_q >= r_dlen) r_state <= S_OUT;
                    else               r_state <= S_SKIP_EX;
                end
                S_SKIP_EX: begin
                    if (r_dict_q == CH_NUL) begin
                        r_state <= S_OUT;
                    end else if (r_dict_q == CH_LF) begin
                        r_state <= S_LEAD_RD;
                    end else begin
                        r_q     <= r_q + 1'b1;
                        r_state <= S_SKIP_RD;
                    end
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_mlen  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: design/sdwd_checker.sv
module sdwd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_req_type,
    input logic       i_in_last,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_is_match
);
    import sdwd_pkg::*;

    // result holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_is_match))
        else $error("result changed while stalled");

    // no input taken while a result waits
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while result pending");

    // a transfer never shows a result in the next cycle
    a_no_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_out_valid)
        else $error("result too early");

    // only the last message byte stops input
    a_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !(i_in_req_type == REQ_MSG && i_in_last)
        |=> i_in_ready)
        else $error("input stalled after ordinary transfer");

endmodule

bind sjis_dictionary_word_detector sdwd_checker u_sdwd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_req_type  (i_in.req_type),
    .i_in_last      (i_in.last),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_is_match (o_out.is_match)
);
